FILE: rtl/core/srfb_pkg.sv
// Shared types, constants and helpers of the shape rasterizer framebuffer.
// Used by every file of the block; depends on nothing.

package srfb_pkg;

   // Board geometry and derived widths.
   localparam int BOARD_SIDE  = 32;
   localparam int COORD_W     = 5;
   localparam int CELLS       = BOARD_SIDE * BOARD_SIDE;
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int COUNT_W     = 11;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int DIST_W      = SQ_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SQ_W-1:0]    square_type;
   typedef logic [2:0]         code_type;

   // Pixel codes held in the framebuffer.
   localparam code_type CODE_BLANK  = 3'd0;
   localparam code_type CODE_POINT  = 3'd1;
   localparam code_type CODE_HEDGE  = 3'd2;
   localparam code_type CODE_VEDGE  = 3'd3;
   localparam code_type CODE_CIRCLE = 3'd4;

   // Command opcodes as they arrive on the request channel.
   typedef enum logic [2:0] {
      OP_POINT  = 3'd0,
      OP_HLINE  = 3'd1,
      OP_VLINE  = 3'd2,
      OP_RECT   = 3'd3,
      OP_CIRCLE = 3'd4,
      OP_READ   = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_DRAW,
      KIND_READ,
      KIND_NONE
   } kind_type;

   typedef enum logic [2:0] {
      SHAPE_POINT,
      SHAPE_HLINE,
      SHAPE_VLINE,
      SHAPE_RECT,
      SHAPE_CIRCLE
   } shape_type;

   // A classified command as it travels from the front end to the draw engine.
   typedef struct packed {
      kind_type   kind;
      shape_type  shape;
      code_type   code;
      coord_type  sx;
      coord_type  sy;
      coord_type  ex;
      coord_type  ey;
      coord_type  x_lo;
      coord_type  x_hi;
      coord_type  y_lo;
      coord_type  y_hi;
      square_type r_sq;
      addr_type   addr;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } back_state_type;

   function automatic coord_type coord_min(coord_type a, coord_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic coord_type coord_max(coord_type a, coord_type b);
      return (a > b) ? a : b;
   endfunction

   // Linear framebuffer address of a board pixel.
   function automatic addr_type pixel_addr(coord_type x, coord_type y);
      return addr_type'(ADDR_W'(y) * ADDR_W'(BOARD_SIDE)) + addr_type'(x);
   endfunction

endpackage

FILE: rtl/core/srfb_req_if.sv
// Request channel of the shape rasterizer framebuffer: one command per beat.
// Depends on srfb_pkg for the field widths.

interface srfb_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   srfb_pkg::coord_type start_x;
   srfb_pkg::coord_type start_y;
   srfb_pkg::coord_type end_x;
   srfb_pkg::coord_type end_y;
   srfb_pkg::coord_type radius;

   modport source (
      output valid, opcode, start_x, start_y, end_x, end_y, radius,
      input  ready
   );

   modport sink (
      input  valid, opcode, start_x, start_y, end_x, end_y, radius,
      output ready
   );
endinterface

FILE: rtl/core/srfb_rsp_if.sv
// Response channel of the shape rasterizer framebuffer: one result per beat.
// Depends on srfb_pkg for the field widths.

interface srfb_rsp_if;
   logic                valid;
   logic                ready;
   srfb_pkg::code_type  pixel_code;
   srfb_pkg::count_type pixels_written;

   modport source (
      output valid, pixel_code, pixels_written,
      input  ready
   );

   modport sink (
      input  valid, pixel_code, pixels_written,
      output ready
   );
endinterface

FILE: rtl/core/srfb_queue.sv
// Two-entry command queue between the front end and the draw engine.
// Depends on srfb_pkg for the command type.

module srfb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  srfb_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output srfb_pkg::cmd_type          head,
   output srfb_pkg::queue_status_type status
);

   srfb_pkg::cmd_type                 entry_ff [srfb_pkg::QUEUE_DEPTH];
   logic [srfb_pkg::QPTR_W-1:0]       wptr_ff, wptr_in;
   logic [srfb_pkg::QPTR_W-1:0]       rptr_ff, rptr_in;
   logic [srfb_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   // Pushes into a full queue and pops from an empty one are ignored.
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   assign status.full  = (count_ff == srfb_pkg::QCNT_W'(srfb_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == srfb_pkg::QPTR_W'(srfb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == srfb_pkg::QPTR_W'(srfb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/srfb_front.sv
// Front end: takes request beats and classifies each into a command with its
// scan window. Depends on srfb_pkg and srfb_req_if.

module srfb_front (
   srfb_req_if.sink                   req_bus,
   input  srfb_pkg::back_ctl_type     back_ctl,
   input  srfb_pkg::queue_status_type q_status,
   output logic                       push,
   output srfb_pkg::cmd_type          push_cmd
);

   logic [srfb_pkg::COORD_W:0] circ_sum;
   srfb_pkg::coord_type        circ_lo, circ_hi;
   srfb_pkg::coord_type        x_min, x_max, y_min, y_max;

   // No command is taken while the framebuffer is being cleared.
   assign req_bus.ready = !back_ctl.clearing && !q_status.full;
   assign push          = req_bus.valid && req_bus.ready;

   assign x_min = srfb_pkg::coord_min(req_bus.start_x, req_bus.end_x);
   assign x_max = srfb_pkg::coord_max(req_bus.start_x, req_bus.end_x);
   assign y_min = srfb_pkg::coord_min(req_bus.start_y, req_bus.end_y);
   assign y_max = srfb_pkg::coord_max(req_bus.start_y, req_bus.end_y);

   // Circle bounding box clipped to the board; the row limits below come from start_y.
   assign circ_sum = {1'b0, req_bus.start_x} + {1'b0, req_bus.radius};
   assign circ_lo  = (req_bus.start_x >= req_bus.radius) ?
                     req_bus.start_x - req_bus.radius : '0;
   assign circ_hi  = (circ_sum > (srfb_pkg::COORD_W + 1)'(srfb_pkg::BOARD_SIDE - 1)) ?
                     srfb_pkg::COORD_W'(srfb_pkg::BOARD_SIDE - 1) :
                     circ_sum[srfb_pkg::COORD_W-1:0];

   logic [srfb_pkg::COORD_W:0] circ_sum_y;
   srfb_pkg::coord_type        circ_lo_y, circ_hi_y;

   assign circ_sum_y = {1'b0, req_bus.start_y} + {1'b0, req_bus.radius};
   assign circ_lo_y  = (req_bus.start_y >= req_bus.radius) ?
                       req_bus.start_y - req_bus.radius : '0;
   assign circ_hi_y  = (circ_sum_y > (srfb_pkg::COORD_W + 1)'(srfb_pkg::BOARD_SIDE - 1)) ?
                       srfb_pkg::COORD_W'(srfb_pkg::BOARD_SIDE - 1) :
                       circ_sum_y[srfb_pkg::COORD_W-1:0];

   // Classification: the draw engine scans the window and tests membership.
   always_comb begin
      push_cmd.kind  = srfb_pkg::KIND_NONE;
      push_cmd.shape = srfb_pkg::SHAPE_POINT;
      push_cmd.code  = srfb_pkg::CODE_BLANK;
      push_cmd.sx    = req_bus.start_x;
      push_cmd.sy    = req_bus.start_y;
      push_cmd.ex    = req_bus.end_x;
      push_cmd.ey    = req_bus.end_y;
      push_cmd.x_lo  = req_bus.start_x;
      push_cmd.x_hi  = req_bus.start_x;
      push_cmd.y_lo  = req_bus.start_y;
      push_cmd.y_hi  = req_bus.start_y;
      push_cmd.r_sq  = srfb_pkg::SQ_W'(req_bus.radius) * srfb_pkg::SQ_W'(req_bus.radius);
      push_cmd.addr  = srfb_pkg::pixel_addr(req_bus.start_x, req_bus.start_y);
      unique case (req_bus.opcode)
         srfb_pkg::OP_POINT: begin
            push_cmd.kind  = srfb_pkg::KIND_DRAW;
            push_cmd.shape = srfb_pkg::SHAPE_POINT;
            push_cmd.code  = srfb_pkg::CODE_POINT;
         end
         srfb_pkg::OP_HLINE: begin
            push_cmd.kind  = srfb_pkg::KIND_DRAW;
            push_cmd.shape = srfb_pkg::SHAPE_HLINE;
            push_cmd.code  = srfb_pkg::CODE_HEDGE;
            push_cmd.x_lo  = x_min;
            push_cmd.x_hi  = x_max;
         end
         srfb_pkg::OP_VLINE: begin
            push_cmd.kind  = srfb_pkg::KIND_DRAW;
            push_cmd.shape = srfb_pkg::SHAPE_VLINE;
            push_cmd.code  = srfb_pkg::CODE_VEDGE;
            push_cmd.y_lo  = y_min;
            push_cmd.y_hi  = y_max;
         end
         srfb_pkg::OP_RECT: begin
            push_cmd.kind  = srfb_pkg::KIND_DRAW;
            push_cmd.shape = srfb_pkg::SHAPE_RECT;
            push_cmd.code  = srfb_pkg::CODE_HEDGE;
            push_cmd.x_lo  = x_min;
            push_cmd.x_hi  = x_max;
            push_cmd.y_lo  = y_min;
            push_cmd.y_hi  = y_max;
         end
         srfb_pkg::OP_CIRCLE: begin
            push_cmd.kind  = srfb_pkg::KIND_DRAW;
            push_cmd.shape = srfb_pkg::SHAPE_CIRCLE;
            push_cmd.code  = srfb_pkg::CODE_CIRCLE;
            push_cmd.x_lo  = circ_lo;
            push_cmd.x_hi  = circ_hi;
            push_cmd.y_lo  = circ_lo_y;
            push_cmd.y_hi  = circ_hi_y;
         end
         srfb_pkg::OP_READ: begin
            push_cmd.kind  = srfb_pkg::KIND_READ;
         end
         default: begin
            push_cmd.kind  = srfb_pkg::KIND_NONE;
         end
      endcase
   end

endmodule

FILE: rtl/core/srfb_back.sv
// Draw engine: holds the framebuffer, scans each command's window one pixel
// a cycle, counts pixels written and drives the response register.
// Depends on srfb_pkg and srfb_rsp_if.

module srfb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  srfb_pkg::cmd_type          head,
   input  srfb_pkg::queue_status_type q_status,
   output srfb_pkg::back_ctl_type     back_ctl,
   srfb_rsp_if.source                 rsp_bus
);

   srfb_pkg::code_type        pixel_mem [srfb_pkg::CELLS];

   srfb_pkg::back_state_type  state_ff, state_in;
   srfb_pkg::cmd_type         cmd_ff, cmd_in;
   srfb_pkg::coord_type       x_ff, x_in;
   srfb_pkg::coord_type       y_ff, y_in;
   srfb_pkg::count_type       count_ff, count_in;
   srfb_pkg::code_type        res_code_ff, res_code_in;
   srfb_pkg::addr_type        clear_addr_ff, clear_addr_in;
   srfb_pkg::code_type        rd_code_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   srfb_pkg::code_type        rsp_code_ff, rsp_code_in;
   srfb_pkg::count_type       rsp_count_ff, rsp_count_in;

   logic                      mem_we;
   srfb_pkg::addr_type        mem_waddr;
   srfb_pkg::code_type        mem_wdata;

   logic signed [srfb_pkg::COORD_W+1:0] dx, dy;
   srfb_pkg::coord_type       adx, ady;
   srfb_pkg::square_type      sq_x, sq_y;
   logic [srfb_pkg::DIST_W-1:0] dist_sq;
   logic                      in_circle, on_row, on_col, in_rect, hit;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.pixel_code     = rsp_code_ff;
   assign rsp_bus.pixels_written = rsp_count_ff;

   // Circle test on the scan position: dx squared plus dy squared against r squared.
   assign dx   = $signed({2'b00, x_ff}) - $signed({2'b00, cmd_ff.sx});
   assign dy   = $signed({2'b00, y_ff}) - $signed({2'b00, cmd_ff.sy});
   assign adx  = dx[srfb_pkg::COORD_W+1] ? srfb_pkg::COORD_W'(-dx) :
                 srfb_pkg::COORD_W'(dx);
   assign ady  = dy[srfb_pkg::COORD_W+1] ? srfb_pkg::COORD_W'(-dy) :
                 srfb_pkg::COORD_W'(dy);
   assign sq_x = srfb_pkg::SQ_W'(adx) * srfb_pkg::SQ_W'(adx);
   assign sq_y = srfb_pkg::SQ_W'(ady) * srfb_pkg::SQ_W'(ady);
   assign dist_sq   = srfb_pkg::DIST_W'(sq_x) + srfb_pkg::DIST_W'(sq_y);
   assign in_circle = (dist_sq <= srfb_pkg::DIST_W'(cmd_ff.r_sq));

   // Rectangle outline: top and bottom rows over start..end columns, both side
   // columns over the rows from the start row up to, but not including, the end row.
   assign on_row  = ((y_ff == cmd_ff.sy) || (y_ff == cmd_ff.ey)) &&
                    (x_ff >= cmd_ff.sx) && (x_ff <= cmd_ff.ex);
   assign on_col  = ((x_ff == cmd_ff.sx) || (x_ff == cmd_ff.ex)) &&
                    (y_ff >= cmd_ff.sy) && (y_ff < cmd_ff.ey);
   assign in_rect = on_row || on_col;

   // Membership of the current scan pixel in the shape.
   always_comb begin
      unique case (cmd_ff.shape)
         srfb_pkg::SHAPE_POINT:  hit = 1'b1;
         srfb_pkg::SHAPE_HLINE:  hit = (x_ff >= cmd_ff.sx) && (x_ff <= cmd_ff.ex);
         srfb_pkg::SHAPE_VLINE:  hit = (y_ff >= cmd_ff.sy) && (y_ff <= cmd_ff.ey);
         srfb_pkg::SHAPE_RECT:   hit = in_rect;
         srfb_pkg::SHAPE_CIRCLE: hit = in_circle;
         default:                hit = 1'b0;
      endcase
   end

   // Sequencer: clearing sweep, command pickup, scan, read and result hand-off.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      count_in      = count_ff;
      res_code_in   = res_code_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_code_in   = rsp_code_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = srfb_pkg::pixel_addr(x_ff, y_ff);
      mem_wdata     = cmd_ff.code;
      back_ctl.clearing = 1'b0;
      back_ctl.pop      = 1'b0;
      unique case (state_ff)
         srfb_pkg::ST_CLEAR: begin
            back_ctl.clearing = 1'b1;
            mem_we        = 1'b1;
            mem_waddr     = clear_addr_ff;
            mem_wdata     = srfb_pkg::CODE_BLANK;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == srfb_pkg::ADDR_W'(srfb_pkg::CELLS - 1)) begin
               state_in = srfb_pkg::ST_IDLE;
            end
         end
         srfb_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               back_ctl.pop = 1'b1;
               cmd_in       = head;
               x_in         = head.x_lo;
               y_in         = head.y_lo;
               count_in     = '0;
               res_code_in  = srfb_pkg::CODE_BLANK;
               unique case (head.kind)
                  srfb_pkg::KIND_DRAW: state_in = srfb_pkg::ST_SCAN;
                  srfb_pkg::KIND_READ: state_in = srfb_pkg::ST_READ;
                  default:             state_in = srfb_pkg::ST_DONE;
               endcase
            end
         end
         srfb_pkg::ST_SCAN: begin
            if (hit) begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
            end
            if (x_ff == cmd_ff.x_hi) begin
               x_in = cmd_ff.x_lo;
               if (y_ff == cmd_ff.y_hi) begin
                  state_in = srfb_pkg::ST_DONE;
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         srfb_pkg::ST_READ: begin
            res_code_in = rd_code_ff;
            state_in    = srfb_pkg::ST_DONE;
         end
         srfb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_count_in = count_ff;
               state_in     = srfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srfb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srfb_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      count_ff     <= count_in;
      res_code_ff  <= res_code_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Framebuffer: one write port, one registered read port at the queue head.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      rd_code_ff <= pixel_mem[head.addr];
   end

endmodule

FILE: rtl/core/shape_rasterizer_framebuffer_unit.sv
// Top level of the shape rasterizer framebuffer: front end, command queue and
// draw engine. Depends on srfb_pkg, srfb_req_if, srfb_rsp_if and the three cores.
//
//   Channel   Direction  Beat carries
//   req_bus   in         opcode, start_x, start_y, end_x, end_y, radius
//   rsp_bus   out        pixel_code, pixels_written
//
// A draw command scans its clipped bounding window one pixel per cycle through
// the single framebuffer write port: a point scans a single pixel, a full-board
// rectangle or circle up to 1024 pixels, plus pickup and hand-off.
// A read passes pickup, a state taking the registered read port, and hand-off.
// After reset all 1024 framebuffer cells are swept to blank, with req ready low.
// Up to two commands wait in the queue while the engine stalls on rsp ready.

module shape_rasterizer_framebuffer_unit (
   input  logic       clock,
   input  logic       reset,
   srfb_req_if.sink   req_bus,
   srfb_rsp_if.source rsp_bus
);

   srfb_pkg::cmd_type          push_cmd;
   srfb_pkg::cmd_type          head;
   srfb_pkg::queue_status_type q_status;
   srfb_pkg::back_ctl_type     back_ctl;
   logic                       push;

   srfb_front u_front (
      .req_bus  (req_bus),
      .back_ctl (back_ctl),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   srfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (back_ctl.pop),
      .head     (head),
      .status   (q_status)
   );

   srfb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .back_ctl (back_ctl),
      .rsp_bus  (rsp_bus)
   );

endmodule
